>>> hw/rtl/spt_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// spt_pkg
// Shared types and constants of the sorted priority table: field widths,
// operation and status codes, the command and response words, and the
// control word that the sequencer broadcasts to the cell chain.
// ============================================================================
package spt_pkg;

    // Default sizes, handed to the top level parameters.
    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF = 16;
    localparam int ID_BITS_DEF  = 16;

    // Fixed widths of the channel fields.
    localparam int OPCODE_W    = 2;
    localparam int KEY_W       = 16;
    localparam int ID_W        = 16;
    localparam int RANK_W      = 6;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;

    // Operation codes.
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // Command word.
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [KEY_W-1:0]    entry_key;
        logic [ID_W-1:0]     entry_id;
        logic [RANK_W-1:0]   rank;
    } cmd_word_t;

    // Response word.
    typedef struct packed {
        logic [ID_W-1:0]        read_id;
        logic [KEY_W-1:0]       read_key;
        logic [STATUS_W-1:0]    status;
        logic [COUNT_OUT_W-1:0] entry_count;
    } rsp_word_t;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;    // Place a new entry, sliding larger keys up by one.
        logic rd_load;   // Copy each cell's entry into its readout stage.
        logic rd_shift;  // Move the readout chain one cell toward the head.
    } cell_ctl_t;

endpackage

>>> hw/rtl/spt_cmd_if.sv
`timescale 1ns / 1ps
// ============================================================================
// spt_cmd_if
// Valid/ready channel that carries command words into the table.
// ============================================================================
interface spt_cmd_if;

    logic              valid;
    logic              ready;
    spt_pkg::cmd_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

>>> hw/rtl/spt_rsp_if.sv
`timescale 1ns / 1ps
// ============================================================================
// spt_rsp_if
// Valid/ready channel that carries response words out of the table.
// ============================================================================
interface spt_rsp_if;

    logic              valid;
    logic              ready;
    spt_pkg::rsp_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

>>> hw/rtl/spt_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// spt_cell
// One slot of the sorted chain. It holds one entry (key and id) and one
// readout stage. On an insert it keeps its entry, takes its left neighbor's
// entry, or takes the new entry; on a read the readout stages form a shift
// line that carries entries toward the head of the chain.
// ============================================================================
module spt_cell #(
    parameter int KEY_BITS = spt_pkg::KEY_BITS_DEF,
    parameter int ID_BITS  = spt_pkg::ID_BITS_DEF,
    parameter int COUNT_W  = 7,
    parameter int INDEX    = 0
) (
    input  logic                clk,
    input  spt_pkg::cell_ctl_t  ctl,
    input  logic [COUNT_W-1:0]  count,
    input  logic [KEY_BITS-1:0] new_key,
    input  logic [ID_BITS-1:0]  new_id,
    input  logic                left_place,
    input  logic [KEY_BITS-1:0] left_key,
    input  logic [ID_BITS-1:0]  left_id,
    input  logic [KEY_BITS-1:0] right_rd_key,
    input  logic [ID_BITS-1:0]  right_rd_id,
    output logic                place,
    output logic [KEY_BITS-1:0] key,
    output logic [ID_BITS-1:0]  id,
    output logic [KEY_BITS-1:0] rd_key,
    output logic [ID_BITS-1:0]  rd_id
);

    logic [KEY_BITS-1:0] key_reg;
    logic [ID_BITS-1:0]  id_reg;
    logic [KEY_BITS-1:0] rd_key_reg;
    logic [ID_BITS-1:0]  rd_id_reg;
    logic                occupied;
    logic                take_left;

    // A slot is occupied when its position lies below the fill count.
    assign occupied = (COUNT_W'(INDEX) < count);

    // The new entry lands at or before this slot when the slot is empty or
    // holds a strictly larger key; equal keys stay ahead of the new one.
    assign place     = !occupied || (key_reg > new_key);
    assign take_left = place && left_place;

    assign key    = key_reg;
    assign id     = id_reg;
    assign rd_key = rd_key_reg;
    assign rd_id  = rd_id_reg;

    // Entry storage: slide up from the left or take the new entry.
    always_ff @(posedge clk)
    begin
        if (ctl.insert && place)
        begin
            if (take_left)
            begin
                key_reg <= left_key;
                id_reg  <= left_id;
            end
            else
            begin
                key_reg <= new_key;
                id_reg  <= new_id;
            end
        end
    end

    // Readout stage: parallel load, then shift toward the head.
    always_ff @(posedge clk)
    begin
        if (ctl.rd_load)
        begin
            rd_key_reg <= key_reg;
            rd_id_reg  <= id_reg;
        end
        else if (ctl.rd_shift)
        begin
            rd_key_reg <= right_rd_key;
            rd_id_reg  <= right_rd_id;
        end
    end

endmodule

>>> hw/rtl/sorted_priority_table.sv
`timescale 1ns / 1ps
// ============================================================================
// sorted_priority_table
// Table of entries kept in ascending key order, built as a chain of cells.
// Supports insert, read at rank and clear, with one response per command.
// ============================================================================
// The table holds up to CAPACITY entries, smallest key at rank 0; entries with
// equal keys keep their order of arrival. An insert, a clear, a refused insert,
// a read at a rank not below the count and an unused opcode each finish at the
// accepting edge: all cells compare the new key in parallel and the response
// word is registered at that edge. A good read at rank r copies the entries
// into a readout shift line that moves one cell toward the head per cycle, and
// the word is written to the response register once entry r has arrived there
// and the register is free. A response that waits in its register holds off
// the input: the next command is accepted only in a cycle in which the response
// register is empty or its word is taken.
// Stored keys and ids are not reset; the fill count, state and response are.
// ============================================================================
module sorted_priority_table #(
    parameter int CAPACITY = spt_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = spt_pkg::KEY_BITS_DEF,
    parameter int ID_BITS  = spt_pkg::ID_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    spt_cmd_if.sink   cmd,
    spt_rsp_if.source rsp
);

    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int RANK_W  = spt_pkg::RANK_W;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [RANK_W-1:0]   cnt_reg, cnt_next;
    logic                rsp_valid_reg, rsp_valid_next;
    spt_pkg::rsp_word_t  rsp_word_reg, rsp_word_next;

    spt_pkg::cell_ctl_t  ctl;
    logic                cmd_fire;
    logic                rsp_free;
    logic                is_insert;
    logic                is_read;
    logic                full;
    logic                rank_ok;
    logic [KEY_BITS-1:0] new_key;
    logic [ID_BITS-1:0]  new_id;

    logic [COUNT_W+RANK_W-1:0]               rank_ext;
    logic [COUNT_W+RANK_W-1:0]               count_ext;
    logic [KEY_BITS+spt_pkg::KEY_W-1:0]      key_in_ext;
    logic [ID_BITS+spt_pkg::ID_W-1:0]        id_in_ext;
    logic [KEY_BITS+spt_pkg::KEY_W-1:0]      key_out_ext;
    logic [ID_BITS+spt_pkg::ID_W-1:0]        id_out_ext;
    logic [COUNT_W+spt_pkg::COUNT_OUT_W-1:0] count_out_ext;

    // Neighbor links of the chain; index 0 and CAPACITY are the chain ends.
    logic                place_chain  [CAPACITY+1];
    logic [KEY_BITS-1:0] key_chain    [CAPACITY+1];
    logic [ID_BITS-1:0]  id_chain     [CAPACITY+1];
    logic [KEY_BITS-1:0] rd_key_chain [CAPACITY+1];
    logic [ID_BITS-1:0]  rd_id_chain  [CAPACITY+1];

    // Handshake and command decode.
    assign rsp_free  = !rsp_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE) && rsp_free;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign is_insert = (cmd.data.opcode == spt_pkg::OP_INSERT);
    assign is_read   = (cmd.data.opcode == spt_pkg::OP_READ);
    assign full      = (count_reg == COUNT_W'(CAPACITY));

    assign rank_ext  = {{COUNT_W{1'b0}}, cmd.data.rank};
    assign count_ext = {{RANK_W{1'b0}}, count_reg};
    assign rank_ok   = (rank_ext < count_ext);

    // Fit the fixed-width fields to the stored widths.
    assign key_in_ext = {{KEY_BITS{1'b0}}, cmd.data.entry_key};
    assign id_in_ext  = {{ID_BITS{1'b0}}, cmd.data.entry_id};
    assign new_key    = key_in_ext[KEY_BITS-1:0];
    assign new_id     = id_in_ext[ID_BITS-1:0];

    assign key_out_ext   = {{spt_pkg::KEY_W{1'b0}}, rd_key_chain[0]};
    assign id_out_ext    = {{spt_pkg::ID_W{1'b0}}, rd_id_chain[0]};
    assign count_out_ext = {{spt_pkg::COUNT_OUT_W{1'b0}}, count_next};

    // Control broadcast to the cells.
    assign ctl.insert   = cmd_fire && is_insert && !full;
    assign ctl.rd_load  = cmd_fire && is_read && rank_ok;
    assign ctl.rd_shift = (state_reg == S_READ) && (cnt_reg != '0);

    // Chain ends: nothing slides in from the left, nothing shifts in from the right.
    assign place_chain[0]         = 1'b0;
    assign key_chain[0]           = '0;
    assign id_chain[0]            = '0;
    assign rd_key_chain[CAPACITY] = '0;
    assign rd_id_chain[CAPACITY]  = '0;

    // The row of cells.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        spt_cell #(
            .KEY_BITS (KEY_BITS),
            .ID_BITS  (ID_BITS),
            .COUNT_W  (COUNT_W),
            .INDEX    (i)
        ) u_cell (
            .clk          (clk),
            .ctl          (ctl),
            .count        (count_reg),
            .new_key      (new_key),
            .new_id       (new_id),
            .left_place   (place_chain[i]),
            .left_key     (key_chain[i]),
            .left_id      (id_chain[i]),
            .right_rd_key (rd_key_chain[i+1]),
            .right_rd_id  (rd_id_chain[i+1]),
            .place        (place_chain[i+1]),
            .key          (key_chain[i+1]),
            .id           (id_chain[i+1]),
            .rd_key       (rd_key_chain[i]),
            .rd_id        (rd_id_chain[i])
        );
    end

    // Sequencer: next state, fill count and response word.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_word_next  = rsp_word_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    rsp_word_next.read_id  = '0;
                    rsp_word_next.read_key = '0;
                    rsp_word_next.status   = spt_pkg::ST_OK;
                    rsp_valid_next         = 1'b1;
                    case (cmd.data.opcode)
                        spt_pkg::OP_INSERT:
                        begin
                            if (full)
                            begin
                                rsp_word_next.status = spt_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        spt_pkg::OP_READ:
                        begin
                            if (rank_ok)
                            begin
                                state_next     = S_READ;
                                cnt_next       = cmd.data.rank;
                                rsp_valid_next = 1'b0;
                            end
                            else
                            begin
                                rsp_word_next.status = spt_pkg::ST_RANGE;
                            end
                        end
                        spt_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                    rsp_word_next.entry_count = count_out_ext[spt_pkg::COUNT_OUT_W-1:0];
                end
            end
            S_READ:
            begin
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - RANK_W'(1);
                end
                else if (rsp_free)
                begin
                    rsp_word_next.read_id     = id_out_ext[spt_pkg::ID_W-1:0];
                    rsp_word_next.read_key    = key_out_ext[spt_pkg::KEY_W-1:0];
                    rsp_word_next.status      = spt_pkg::ST_OK;
                    rsp_word_next.entry_count = count_out_ext[spt_pkg::COUNT_OUT_W-1:0];
                    rsp_valid_next            = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_word_reg  <= rsp_word_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_word_reg;

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // A good read sends the sequencer into the readout walk.
    a_read_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rd_load |=> (state_reg == S_READ))
        else $error("read accepted but readout walk not started");

    // A refused insert leaves the count alone.
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && is_insert && full |=> (count_reg == $past(count_reg)))
        else $error("count changed on refused insert");

    // An accepted insert grows the count by one.
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.insert |=> (count_reg == $past(count_reg) + COUNT_W'(1)))
        else $error("count not advanced on insert");

    // A response that reports a bad rank carries no entry.
    a_range_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_word_reg.status == spt_pkg::ST_RANGE)
        |-> (rsp_word_reg.read_id == '0) && (rsp_word_reg.read_key == '0))
        else $error("out-of-range response carries data");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the sorted priority table. A queue of command words
// (a short directed opening, then random fill, read and clear episodes) feeds
// a clocked driver. A clocked monitor compares every response word with the
// prediction of a behavioral copy of the table, while both channel ends idle
// and stall at random in rotating phases.
// ============================================================================
module tb_top;

    import spt_pkg::*;

    localparam int DEPTH        = CAPACITY_DEF;
    localparam int PHASE_LEN    = 60;
    localparam int PRESSURE_AT  = 250;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = DEPTH + 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 430;

    // Opcode that the block decodes as no operation.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    // Idling phases, rotated every PHASE_LEN accepted words.
    typedef enum int {PH_STEADY, PH_SRC_IDLE, PH_SINK_STALL, PH_BOTH} idle_phase_t;

    logic clk = 1'b0;
    logic rst_n;

    spt_cmd_if cmd ();
    spt_rsp_if rsp ();

    sorted_priority_table u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    // Behavioral copy of the table.
    logic [KEY_W-1:0] sorted_key [DEPTH];
    logic [ID_W-1:0]  sorted_id  [DEPTH];
    int               held_count = 0;

    cmd_word_t cmd_backlog  [$];
    rsp_word_t expected_rsp [$];

    int gen_fill   = 0;
    int n_accepted = 0;
    int n_errors   = 0;
    int n_cycles   = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    int n_insert = 0;
    int n_full   = 0;
    int n_read   = 0;
    int n_range  = 0;
    int n_clear  = 0;
    int n_unused = 0;

    always #2 clk = ~clk;

    // Apply one command to the table copy and return the response it gives.
    function automatic rsp_word_t table_apply(cmd_word_t c);
        rsp_word_t r;
        int        pos;
        r = '0;
        case (c.opcode)
            OP_INSERT:
            begin
                n_insert++;
                if (held_count >= DEPTH)
                begin
                    r.status = ST_FULL;
                    n_full++;
                end
                else
                begin
                    // Larger keys move up; equal keys stay ahead of the new one.
                    pos = held_count;
                    while (pos > 0 && sorted_key[pos-1] > c.entry_key)
                    begin
                        sorted_key[pos] = sorted_key[pos-1];
                        sorted_id[pos]  = sorted_id[pos-1];
                        pos--;
                    end
                    sorted_key[pos] = c.entry_key;
                    sorted_id[pos]  = c.entry_id;
                    held_count++;
                end
            end
            OP_READ:
            begin
                n_read++;
                if (int'(c.rank) < held_count)
                begin
                    r.read_id  = sorted_id[c.rank];
                    r.read_key = sorted_key[c.rank];
                end
                else
                begin
                    r.status = ST_RANGE;
                    n_range++;
                end
            end
            OP_CLEAR:
            begin
                held_count = 0;
                n_clear++;
            end
            default:
                n_unused++;
        endcase
        r.entry_count = COUNT_OUT_W'(held_count);
        return r;
    endfunction

    // Append a command word and track the count the table will hold.
    task automatic queue_cmd(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] k,
                             input logic [ID_W-1:0] id, input logic [RANK_W-1:0] rk);
        cmd_word_t c;
        c.opcode    = op;
        c.entry_key = k;
        c.entry_id  = id;
        c.rank      = rk;
        cmd_backlog.push_back(c);
        if (op == OP_INSERT && gen_fill < DEPTH)
            gen_fill++;
        else if (op == OP_CLEAR)
            gen_fill = 0;
    endtask

    function automatic idle_phase_t phase_now();
        return idle_phase_t'((n_accepted / PHASE_LEN) % 4);
    endfunction

    function automatic bit sender_idles();
        if (hold_left != 0)
            return 1'b0;
        case (phase_now())
            PH_SRC_IDLE: return $urandom_range(0, 99) < 84;
            PH_BOTH:     return $urandom_range(0, 99) < 27;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_ready();
        if (hold_left != 0)
            return 1'b0;
        case (phase_now())
            PH_SINK_STALL: return $urandom_range(0, 99) >= 84;
            PH_BOTH:       return $urandom_range(0, 99) >= 27;
            default:       return 1'b1;
        endcase
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Driver: predict each accepted word, then offer the next one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd.valid && cmd.ready)
            begin
                expected_rsp.push_back(table_apply(cmd.data));
                n_accepted <= n_accepted + 1;
            end
            if (!cmd.valid || cmd.ready)
            begin
                if (cmd_backlog.size() != 0 && !sender_idles())
                begin
                    cmd.valid <= 1'b1;
                    cmd.data  <= cmd_backlog.pop_front();
                end
                else
                    cmd.valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted response against the oldest prediction.
    always @(posedge clk)
    begin
        rsp_word_t want;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $display("%0t: unexpected response word, actual %p", $time, rsp.data);
                    n_errors++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    compare_field("read_id", want.read_id, rsp.data.read_id);
                    compare_field("read_key", want.read_key, rsp.data.read_key);
                    compare_field("status", want.status, rsp.data.status);
                    compare_field("entry_count", want.entry_count, rsp.data.entry_count);
                end
            end
            rsp.ready <= receiver_ready();
        end
    end

    // Long receiver hold-off once, while the sender keeps offering words.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && n_accepted >= PRESSURE_AT)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, n_cycles);
            $display("tb_top failed");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int               n_random;
        int               ep_len;
        int               pick;
        bit               fill_up;
        logic [KEY_W-1:0] key_span;
        logic [OPCODE_W-1:0] op;
        logic [RANK_W-1:0]   rk;

        cmd.valid = 1'b0;
        cmd.data  = '0;
        rsp.ready = 1'b0;
        rst_n     = 1'b0;

        // Directed opening: empty read, key extremes, equal keys, every rank held.
        queue_cmd(OP_READ,   16'h0000, 16'h0000, 6'd0);
        queue_cmd(OP_INSERT, 16'hFFFF, 16'hFFFF, 6'd0);
        queue_cmd(OP_INSERT, 16'h0000, 16'h0000, 6'd63);
        queue_cmd(OP_INSERT, 16'h8000, 16'h1234, 6'd0);
        queue_cmd(OP_INSERT, 16'h8000, 16'h5678, 6'd0);
        queue_cmd(OP_INSERT, 16'h0000, 16'hAAAA, 6'd0);
        for (int i = 0; i < 5; i++)
            queue_cmd(OP_READ, 16'hFFFF, 16'hFFFF, RANK_W'(i));
        queue_cmd(OP_READ,   16'h0000, 16'h0000, 6'd5);
        queue_cmd(OP_READ,   16'h0000, 16'h0000, 6'd63);
        queue_cmd(OP_UNUSED, 16'hFFFF, 16'hFFFF, 6'd63);
        queue_cmd(OP_READ,   16'h0000, 16'h0000, 6'd4);
        queue_cmd(OP_CLEAR,  16'hFFFF, 16'hFFFF, 6'd63);
        queue_cmd(OP_READ,   16'h0000, 16'h0000, 6'd0);
        queue_cmd(OP_INSERT, 16'h5555, 16'h3C3C, 6'd21);
        queue_cmd(OP_READ,   16'hAAAA, 16'hC3C3, 6'd0);

        // Random episodes: fills up to and past full, small key sets for ties.
        n_random = 0;
        while (n_random < RANDOM_ITEMS)
        begin
            fill_up  = ($urandom_range(0, 2) == 0);
            key_span = ($urandom_range(0, 1) == 0) ? 16'h0007 : 16'hFFFF;
            ep_len   = fill_up ? $urandom_range(80, 110) : $urandom_range(5, 40);
            if ($urandom_range(0, 3) != 0)
            begin
                queue_cmd(OP_CLEAR, KEY_W'($urandom()), ID_W'($urandom()),
                          RANK_W'($urandom()));
                n_random++;
            end
            for (int i = 0; i < ep_len && n_random < RANDOM_ITEMS; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < (fill_up ? 80 : 50))
                    op = OP_INSERT;
                else if (pick < 94)
                    op = OP_READ;
                else if (pick < 97)
                    op = OP_UNUSED;
                else
                    op = OP_CLEAR;
                rk = RANK_W'($urandom());
                if (op == OP_READ && gen_fill > 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       rk = RANK_W'($urandom());
                        1:       rk = RANK_W'(gen_fill - 1);
                        default: rk = RANK_W'($urandom_range(0, gen_fill - 1));
                    endcase
                end
                queue_cmd(op, KEY_W'($urandom()) & key_span, ID_W'($urandom()), rk);
                n_random++;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || cmd.valid)
            @(posedge clk);
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d words: %0d inserts (%0d refused as full), %0d reads",
                 n_accepted, n_insert, n_full, n_read);
        $display("(%0d out of range), %0d clears and %0d unused opcodes.",
                 n_range, n_clear, n_unused);
        if (n_errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/spt_pkg.sv
hw/rtl/spt_cmd_if.sv
hw/rtl/spt_rsp_if.sv
hw/rtl/spt_cell.sv
hw/rtl/sorted_priority_table.sv
sim/tb_top.sv
